### hdl/tpi_pkg.sv
// Package for the turtle path interpreter: constants, codes, types and the sine table.
package tpi_pkg;

  localparam int STACK_DEPTH        = 64;
  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int SINE_KW            = $clog2(SINE_TABLE_ENTRIES);
  localparam int SINE_QUARTER       = SINE_TABLE_ENTRIES / 4;
  localparam int STACK_CW           = $clog2(STACK_DEPTH + 1);

  localparam int POS_W   = 20;
  localparam int HEAD_W  = 16;
  localparam int STEP_W  = 12;
  localparam int TURN_W  = 16;
  localparam int MAG_W   = 15;
  localparam int TRIG_W  = MAG_W + 1;
  localparam int TRIG_FRAC = 14;
  localparam int PROD_W  = STEP_W + 1 + TRIG_W;
  localparam int DELTA_W = PROD_W - TRIG_FRAC;
  localparam int SYM_W   = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_PLUS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_MINUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd5;

  localparam logic [STEP_W-1:0]        RST_STEP_LENGTH   = 12'h280;
  localparam logic signed [TURN_W-1:0] RST_TURN_PLUS     = 16'sh061D;
  localparam logic signed [TURN_W-1:0] RST_TURN_MINUS    = 16'shF9E3;
  localparam logic signed [POS_W-1:0]  RST_START_X       = 20'sh08000;
  localparam logic signed [POS_W-1:0]  RST_START_Y       = 20'sh10000;
  localparam logic [HEAD_W-1:0]        RST_START_HEADING = 16'h7FF0;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  localparam logic [SYM_W-1:0] SYM_MOVE  = 8'h46;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_PUSH  = 8'h5B;
  localparam logic [SYM_W-1:0] SYM_POP   = 8'h5D;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
  localparam logic [OP_W-1:0] OP_MOVE    = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH    = 3'd2;
  localparam logic [OP_W-1:0] OP_POP     = 3'd3;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_MOVE = 2'd2;

  localparam logic [1:0] FAULT_OK    = 2'd0;
  localparam logic [1:0] FAULT_OVER  = 2'd1;
  localparam logic [1:0] FAULT_UNDER = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic h_push;
    logic h_pop;
    logic p_push;
    logic p_pop;
  } stk_ctl_t;

  function automatic int sine_mag(input int k);
    longint unsigned p;
    longint unsigned q;
    longint unsigned t;
    longint unsigned u;
    longint unsigned a;
    longint unsigned s;
    p = (longint'(k) << 32) / SINE_TABLE_ENTRIES;
    q = (p >> 30) & 64'd3;
    t = p & 64'h3FFF_FFFF;
    if (q[0]) t = (64'd1 << 30) - t;
    u = (t * t) >> 30;
    a = 64'd172272;
    a = 64'd5026994 - ((u * a) >> 30);
    a = 64'd85569306 - ((u * a) >> 30);
    a = 64'd693598670 - ((u * a) >> 30);
    a = 64'd1686629713 - ((u * a) >> 30);
    s = (t * a) >> 30;
    return int'((s + (64'd1 << 15)) >> 16);
  endfunction

  typedef logic [MAG_W-1:0] sine_qtr_t [SINE_QUARTER];

  function automatic sine_qtr_t build_sine_qtr();
    sine_qtr_t tbl;
    for (int j = 0; j < SINE_QUARTER; j++) begin
      tbl[j] = MAG_W'(sine_mag(j));
    end
    return tbl;
  endfunction

  localparam sine_qtr_t SINE_QTR = build_sine_qtr();
  localparam logic [MAG_W-1:0] SINE_PEAK = MAG_W'(sine_mag(SINE_QUARTER));

  function automatic logic signed [TRIG_W-1:0] trig_value(input logic [SINE_KW-1:0] k);
    logic [1:0]         q;
    logic [SINE_KW-3:0] r;
    logic [SINE_KW-3:0] rf;
    logic [MAG_W-1:0]   mag;
    q  = k[SINE_KW-1 -: 2];
    r  = k[SINE_KW-3:0];
    rf = (~r) + {{(SINE_KW-3){1'b0}}, 1'b1};
    if (q[0] && (r == '0)) begin
      mag = SINE_PEAK;
    end else if (q[0]) begin
      mag = SINE_QTR[rf];
    end else begin
      mag = SINE_QTR[r];
    end
    if (q[1]) return -$signed({1'b0, mag});
    return $signed({1'b0, mag});
  endfunction

endpackage

### hdl/turtle_path_interpreter_unit.sv
// Top level of the turtle path interpreter: decode, step scaling and position pipeline.
//
// Input channel in_*: one symbol item per handshake, in_tuser flags a restart.
// Result channel out_*: exactly one result item per input item, in order.
// Config cfg_*: register writes, always ready; user must write only while idle; unenforced.
// Pipeline: stage 1 decodes the symbol, updates heading and stack count and
// reads sine and cosine of the current heading from the quarter-wave table;
// stage 2 scales both by the step length (one multiplier per axis); stage 3
// updates the position, saturating, and holds the result item.
// Result path: a result item passes the registers of stages 1, 2 and 3
// before it is valid on out_*.
// Throughput: one item per cycle while out_tready is high; heading and position each
// close their feedback loop through one register, the pose stack is a row of shift cells.
// Reset: registers load their reset values, the pose loads the start pose,
// the stack is empty; no clearing pass is needed.
// Stall: a result waits in the output stage; earlier stages keep accepting
// until all three stages hold items, then in_tready drops.
module turtle_path_interpreter_unit
  import tpi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] symbol
  input  logic                  in_tuser,   // [0] restart
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // [19:0] point_x, [39:20] point_y, [41:40] fault
  output logic [1:0]            out_tuser,  // [1:0] segment_kind
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [STEP_W-1:0]        step_r;
  logic signed [TURN_W-1:0] turn_plus_r;
  logic signed [TURN_W-1:0] turn_minus_r;
  logic signed [POS_W-1:0]  start_x_r;
  logic signed [POS_W-1:0]  start_y_r;
  logic [HEAD_W-1:0]        start_heading_r;

  logic                     en1;
  logic                     en2;
  logic                     en3;
  logic                     in_fire;

  logic [HEAD_W-1:0]        heading_r;
  logic [HEAD_W-1:0]        heading_nxt;
  logic [STACK_CW-1:0]      stack_cnt_r;
  logic [STACK_CW-1:0]      stack_cnt_nxt;
  logic [OP_W-1:0]          dec_op;
  logic [1:0]               dec_fault;

  logic                     s1_valid_r;
  logic [OP_W-1:0]          s1_op_r;
  logic [1:0]               s1_fault_r;
  logic signed [TRIG_W-1:0] s1_sin_r;
  logic signed [TRIG_W-1:0] s1_cos_r;

  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] rnd_x;
  logic signed [PROD_W-1:0] rnd_y;

  logic                     s2_valid_r;
  logic [OP_W-1:0]          s2_op_r;
  logic [1:0]               s2_fault_r;
  logic signed [DELTA_W-1:0] s2_dx_r;
  logic signed [DELTA_W-1:0] s2_dy_r;

  logic                     out_valid_r;
  logic [1:0]               out_kind_r;
  logic [1:0]               out_fault_r;
  logic signed [POS_W-1:0]  pos_x_r;
  logic signed [POS_W-1:0]  pos_y_r;
  logic [1:0]               kind_nxt;

  stk_ctl_t                 stk_ctl;
  logic [HEAD_W-1:0]        h_top;
  point_t                   p_top;
  point_t                   p_cur;

  function automatic logic signed [POS_W-1:0] step_sat(
    input logic signed [POS_W-1:0]   pos,
    input logic signed [DELTA_W-1:0] d
  );
    logic signed [POS_W:0] sum;
    sum = {pos[POS_W-1], pos} + {{(POS_W+1-DELTA_W){d[DELTA_W-1]}}, d};
    if (sum > $signed({POS_MAX[POS_W-1], POS_MAX})) return POS_MAX;
    if (sum < $signed({POS_MIN[POS_W-1], POS_MIN})) return POS_MIN;
    return sum[POS_W-1:0];
  endfunction

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r          <= RST_STEP_LENGTH;
      turn_plus_r     <= RST_TURN_PLUS;
      turn_minus_r    <= RST_TURN_MINUS;
      start_x_r       <= RST_START_X;
      start_y_r       <= RST_START_Y;
      start_heading_r <= RST_START_HEADING;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEP_LENGTH:   step_r          <= cfg_data[STEP_W-1:0];
        REG_TURN_PLUS:     turn_plus_r     <= cfg_data[TURN_W-1:0];
        REG_TURN_MINUS:    turn_minus_r    <= cfg_data[TURN_W-1:0];
        REG_START_X:       start_x_r       <= cfg_data[POS_W-1:0];
        REG_START_Y:       start_y_r       <= cfg_data[POS_W-1:0];
        REG_START_HEADING: start_heading_r <= cfg_data[HEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  assign en3       = !out_valid_r || out_tready;
  assign en2       = !s2_valid_r || en3;
  assign en1       = !s1_valid_r || en2;
  assign in_tready = en1;
  assign in_fire   = in_tvalid && en1;

  // stage 1: decode, heading and stack count
  always_comb begin
    dec_op        = OP_NONE;
    dec_fault     = FAULT_OK;
    heading_nxt   = heading_r;
    stack_cnt_nxt = stack_cnt_r;
    if (in_tuser) begin
      dec_op        = OP_RESTART;
      heading_nxt   = start_heading_r;
      stack_cnt_nxt = '0;
    end else begin
      unique case (in_tdata)
        SYM_MOVE:  dec_op = OP_MOVE;
        SYM_PLUS:  heading_nxt = heading_r + HEAD_W'(turn_plus_r);
        SYM_MINUS: heading_nxt = heading_r + HEAD_W'(turn_minus_r);
        SYM_PUSH: begin
          if (stack_cnt_r == STACK_CW'(STACK_DEPTH)) begin
            dec_fault = FAULT_OVER;
          end else begin
            dec_op        = OP_PUSH;
            stack_cnt_nxt = stack_cnt_r + {{(STACK_CW-1){1'b0}}, 1'b1};
          end
        end
        SYM_POP: begin
          if (stack_cnt_r == '0) begin
            dec_fault = FAULT_UNDER;
          end else begin
            dec_op        = OP_POP;
            heading_nxt   = h_top;
            stack_cnt_nxt = stack_cnt_r - {{(STACK_CW-1){1'b0}}, 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r   <= RST_START_HEADING;
      stack_cnt_r <= '0;
    end else if (in_fire) begin
      heading_r   <= heading_nxt;
      stack_cnt_r <= stack_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op_r    <= dec_op;
      s1_fault_r <= dec_fault;
      s1_sin_r   <= trig_value(heading_r[HEAD_W-1 -: SINE_KW]);
      s1_cos_r   <= trig_value(heading_r[HEAD_W-1 -: SINE_KW] + SINE_KW'(SINE_QUARTER));
    end
  end

  // stage 2: scale by step length, round half up
  assign prod_x = $signed({1'b0, step_r}) * s1_sin_r;
  assign prod_y = $signed({1'b0, step_r}) * s1_cos_r;
  assign rnd_x  = prod_x + PROD_W'(1 << (TRIG_FRAC - 1));
  assign rnd_y  = prod_y + PROD_W'(1 << (TRIG_FRAC - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_op_r    <= s1_op_r;
      s2_fault_r <= s1_fault_r;
      s2_dx_r    <= rnd_x[PROD_W-1:TRIG_FRAC];
      s2_dy_r    <= rnd_y[PROD_W-1:TRIG_FRAC];
    end
  end

  // stage 3: position and result item
  always_comb begin
    unique case (s2_op_r)
      OP_MOVE:            kind_nxt = KIND_LINE;
      OP_POP, OP_RESTART: kind_nxt = KIND_MOVE;
      default:            kind_nxt = KIND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_x_r     <= RST_START_X;
      pos_y_r     <= RST_START_Y;
    end else if (en3) begin
      out_valid_r <= s2_valid_r;
      if (s2_valid_r) begin
        unique case (s2_op_r)
          OP_MOVE: begin
            pos_x_r <= step_sat(pos_x_r, s2_dx_r);
            pos_y_r <= step_sat(pos_y_r, s2_dy_r);
          end
          OP_POP: begin
            pos_x_r <= p_top.x;
            pos_y_r <= p_top.y;
          end
          OP_RESTART: begin
            pos_x_r <= start_x_r;
            pos_y_r <= start_y_r;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_kind_r  <= kind_nxt;
      out_fault_r <= s2_fault_r;
    end
  end

  // pose stack
  assign p_cur.x = pos_x_r;
  assign p_cur.y = pos_y_r;

  assign stk_ctl.h_push = in_fire && (dec_op == OP_PUSH);
  assign stk_ctl.h_pop  = in_fire && (dec_op == OP_POP);
  assign stk_ctl.p_push = en3 && s2_valid_r && (s2_op_r == OP_PUSH);
  assign stk_ctl.p_pop  = en3 && s2_valid_r && (s2_op_r == OP_POP);

  tpi_pose_stack u_stack (
    .clk        (clk),
    .ctl        (stk_ctl),
    .h_push_val (heading_r),
    .p_push_val (p_cur),
    .h_top      (h_top),
    .p_top      (p_top)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_fault_r, pos_y_r, pos_x_r};
  assign out_tuser  = out_kind_r;

endmodule

### hdl/tpi_pose_cell.sv
// One cell of the pose stack: a saved heading and point that shift with the neighbors.
module tpi_pose_cell
  import tpi_pkg::*;
(
  input  logic              clk,
  input  stk_ctl_t          ctl,
  input  logic [HEAD_W-1:0] h_above,
  input  logic [HEAD_W-1:0] h_below,
  input  point_t            p_above,
  input  point_t            p_below,
  output logic [HEAD_W-1:0] h_q,
  output point_t            p_q
);

  logic [HEAD_W-1:0] h_r;
  point_t            p_r;

  always_ff @(posedge clk) begin
    if (ctl.h_push) begin
      h_r <= h_above;
    end else if (ctl.h_pop) begin
      h_r <= h_below;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.p_push) begin
      p_r <= p_above;
    end else if (ctl.p_pop) begin
      p_r <= p_below;
    end
  end

  assign h_q = h_r;
  assign p_q = p_r;

endmodule

### hdl/tpi_pose_stack.sv
// Shift stack of saved poses built from a row of pose cells; cell zero is the top.
module tpi_pose_stack
  import tpi_pkg::*;
(
  input  logic              clk,
  input  stk_ctl_t          ctl,
  input  logic [HEAD_W-1:0] h_push_val,
  input  point_t            p_push_val,
  output logic [HEAD_W-1:0] h_top,
  output point_t            p_top
);

  logic [HEAD_W-1:0] h_cell [STACK_DEPTH];
  point_t            p_cell [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [HEAD_W-1:0] h_above;
    logic [HEAD_W-1:0] h_below;
    point_t            p_above;
    point_t            p_below;

    if (i == 0) begin : g_top
      assign h_above = h_push_val;
      assign p_above = p_push_val;
    end else begin : g_mid
      assign h_above = h_cell[i-1];
      assign p_above = p_cell[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign h_below = '0;
      assign p_below = '0;
    end else begin : g_up
      assign h_below = h_cell[i+1];
      assign p_below = p_cell[i+1];
    end

    tpi_pose_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .h_above (h_above),
      .h_below (h_below),
      .p_above (p_above),
      .p_below (p_below),
      .h_q     (h_cell[i]),
      .p_q     (p_cell[i])
    );
  end

  assign h_top = h_cell[0];
  assign p_top = p_cell[0];

endmodule
